[src/assert_macros.svh]
// Assertion macros shared by the calendar date counter RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define CDC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define CDC_NEVER(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define CDC_ASSERT(name, clk, rstn, prop, msg)
`define CDC_NEVER(name, clk, rstn, expr, msg)

`endif

`endif

[src/caldate_pkg.sv]
// Shared types, constants and calendar helper functions for the date counter.
// No dependencies; imported by caldate_evtab and the top level.
`timescale 1ns / 1ps
`default_nettype none

package caldate_pkg;

  localparam int unsigned NUM_EVENTS = 8;
  localparam int unsigned EvAw  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned HitW  = 8;
  localparam int unsigned ScanN = (NUM_EVENTS < HitW) ? NUM_EVENTS : HitW;

  localparam logic [13:0] BaseYear = 14'd1754;
  localparam logic [13:0] TopYear  = 14'd9999;

  // Reciprocal constants: x / 100 == (x * 5243) >> 19 for x below 43699,
  // x / 7 == (x * 18725) >> 17 for x below 43690.
  localparam int unsigned Div100Mul = 5243;
  localparam int unsigned Div100Sh  = 19;
  localparam int unsigned Div7Mul   = 18725;
  localparam int unsigned Div7Sh    = 17;

  typedef enum logic [2:0] {
    REQ_SET   = 3'd0,
    REQ_NEXT  = 3'd1,
    REQ_PREV  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [5:0] day;
    logic [3:0]        month;
    logic [13:0]       year;
    logic [2:0]        weekday;
  } ev_entry_t;

  localparam int unsigned EntryW = $bits(ev_entry_t);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        last;
  } date_t;

  typedef struct packed {
    logic      wr_en;
    logic [2:0] wr_idx;
    logic      wr_valid;
    ev_entry_t wr_entry;
    logic      scan_start;
  } ev_ctl_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] doy_base(input logic [3:0] month);
    logic [8:0] days;
    unique case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Leap rule on a year held as century and year within the century.
  function automatic logic is_leap(input logic [6:0] yic, input logic [6:0] cent);
    return (yic == 7'd0) ? (cent[1:0] == 2'b00) : (yic[1:0] == 2'b00);
  endfunction

endpackage

`default_nettype wire

[src/caldate_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module caldate_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/caldate_evtab.sv]
// Event pattern table: entries in a RAM, valid bits in flops, and a scan
// that reads one entry per cycle and builds the hit mask. Uses caldate_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module caldate_evtab (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  caldate_pkg::ev_ctl_t          ctl_i,
  input  caldate_pkg::date_t            date_i,
  output logic [caldate_pkg::HitW-1:0]  hits_o,
  output logic                          scan_done_o
);
  import caldate_pkg::*;

  localparam logic [EvAw-1:0] LastIdx = EvAw'(ScanN - 1);

  logic [NUM_EVENTS-1:0] valid_q;
  logic                  wr_ok;
  logic [EvAw-1:0]       wr_addr;
  logic                  busy_q;
  logic [EvAw-1:0]       rd_idx_q;
  logic                  cmp_vld_q;
  logic [EvAw-1:0]       cmp_idx_q;
  logic [HitW-1:0]       hits_q;
  logic [HitW-1:0]       hits_d;
  logic [HitW-1:0]       valid_view;
  logic [EntryW-1:0]     rd_data;
  ev_entry_t             ent;
  logic                  day_m;
  logic                  match;

  assign wr_ok   = ctl_i.wr_en && (32'(ctl_i.wr_idx) < NUM_EVENTS);
  assign wr_addr = EvAw'(ctl_i.wr_idx);

  caldate_ram #(
    .Width (EntryW),
    .Depth (NUM_EVENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (ctl_i.wr_entry),
    .re_i    (busy_q),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  assign ent = ev_entry_t'(rd_data);

  // A day pattern of all ones stands for the last day of the month.
  assign day_m = (ent.day == 6'sd0) ||
                 (!ent.day[5] && (ent.day[4:0] == date_i.day)) ||
                 ((ent.day == 6'b111111) && date_i.last);

  assign match = valid_q[cmp_idx_q] && day_m &&
                 ((ent.month == 4'd0) || (ent.month == date_i.month)) &&
                 ((ent.year == 14'd0) || (ent.year == date_i.year)) &&
                 ((ent.weekday == 3'd0) || (ent.weekday == date_i.weekday));

  always_comb begin
    hits_d = hits_q;
    if (ctl_i.scan_start) begin
      hits_d = '0;
    end else if (cmp_vld_q && match) begin
      for (int b = 0; b < ScanN; b++) begin
        if (cmp_idx_q == EvAw'(b)) begin
          hits_d[b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_view = '0;
    for (int b = 0; b < ScanN; b++) begin
      valid_view[b] = valid_q[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      busy_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[wr_addr] <= ctl_i.wr_valid;
      end
      if (ctl_i.scan_start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (rd_idx_q == LastIdx)) begin
        busy_q <= 1'b0;
      end
      cmp_vld_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_start) begin
      rd_idx_q <= '0;
    end else if (busy_q && (rd_idx_q != LastIdx)) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
    cmp_idx_q <= rd_idx_q;
    hits_q    <= hits_d;
  end

  assign hits_o      = hits_q;
  assign scan_done_o = cmp_vld_q && (cmp_idx_q == LastIdx);

  `CDC_ASSERT(a_no_write_in_scan, clk_i, rst_ni, ctl_i.wr_en |-> (!busy_q && !cmp_vld_q), "table write during scan")
  `CDC_ASSERT(a_hits_only_valid, clk_i, rst_ni, scan_done_o |=> ((hits_q & ~valid_view) == '0), "hit on an invalid entry")

endmodule

`default_nettype wire

[src/calendar_date_counter_with_event_match.sv]
// Top level of the calendar date counter; uses caldate_pkg, caldate_evtab
// and, through it, caldate_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Gregorian date counter (1754-01-01 to 9999-12-31) with an 8-entry event
// pattern table. Requests are taken one at a time; after each, the table RAM
// is scanned one entry per clock and one result transfer is produced. A query,
// day step or table write goes through ST_EXEC, the RAM scan in ST_SCAN and
// ST_OUT before the next request is taken; a date set adds the weekday
// arithmetic of ST_SET1 to ST_SET4 (ST_SET1 and ST_SET2 when it is rejected).
// The finished result sits in an output register, so the next request is
// taken while the previous result still waits. After reset the date is
// Tuesday 1 Jan 1754 and every table entry is invalid.
module calendar_date_counter_with_event_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic signed [5:0]            day_value_i,
  input  logic [3:0]                   month_value_i,
  input  logic [13:0]                  year_value_i,
  input  logic [2:0]                   weekday_value_i,
  input  logic [2:0]                   entry_index_i,
  input  logic                         entry_enable_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [4:0]                   day_out_o,
  output logic [3:0]                   month_out_o,
  output logic [13:0]                  year_out_o,
  output logic [2:0]                   weekday_out_o,
  output logic                         last_of_month_o,
  output logic [caldate_pkg::HitW-1:0] event_hits_o
);
  import caldate_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SET1 = 3'd2;
  localparam logic [2:0] ST_SET2 = 3'd3;
  localparam logic [2:0] ST_SET3 = 3'd4;
  localparam logic [2:0] ST_SET4 = 3'd5;
  localparam logic [2:0] ST_SCAN = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  // Request as taken.
  logic [2:0]        req_q;
  logic signed [5:0] dval_q;
  logic [3:0]        mval_q;
  logic [13:0]       yval_q;
  logic [2:0]        wval_q;
  logic [2:0]        idx_q;
  logic              en_q;

  // Current date; the year is also kept split into century and year in century.
  logic [4:0]  cur_day_q, cur_day_d;
  logic [3:0]  cur_month_q, cur_month_d;
  logic [13:0] cur_year_q, cur_year_d;
  logic [2:0]  cur_wday_q, cur_wday_d;
  logic [6:0]  cur_cent_q, cur_cent_d;
  logic [6:0]  cur_yic_q, cur_yic_d;
  logic        cur_leap;
  logic [4:0]  cur_mlen;
  logic        cur_last;
  logic [3:0]  prev_month;

  // Date set arithmetic.
  logic [6:0]  set_c_q, set_c_d;
  logic [6:0]  set_yic_q, set_yic_d;
  logic        set_leap_q, set_leap_d;
  logic [13:0] n_q, n_d;
  logic [10:0] q7_q, q7_d;
  logic [26:0] c_prod;
  logic [13:0] c100;
  logic [13:0] yic_full;
  logic        set_ok;
  logic [15:0] n_sum;
  logic [28:0] q7_prod;
  logic [13:0] q7_times7;
  logic [13:0] wd_rem;

  status_e status_q, status_d;

  ev_ctl_t    ev_ctl;
  date_t      cur_date;
  logic [HitW-1:0] hits;
  logic       scan_done;

  logic       out_load;
  logic       out_valid_q;
  status_e    out_status_q;
  logic [4:0] out_day_q;
  logic [3:0] out_month_q;
  logic [13:0] out_year_q;
  logic [2:0] out_wday_q;
  logic       out_last_q;
  logic [HitW-1:0] out_hits_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cur_leap   = is_leap(cur_yic_q, cur_cent_q);
  assign cur_mlen   = month_len(cur_month_q, cur_leap);
  assign cur_last   = (cur_day_q == cur_mlen);
  assign prev_month = (cur_month_q <= 4'd1) ? 4'd12 : cur_month_q - 4'd1;

  // Century of the requested year by reciprocal multiply.
  assign c_prod   = 27'(yval_q) * 27'(Div100Mul);
  assign c100     = 14'(set_c_q) * 14'd100;
  assign yic_full = yval_q - c100;

  assign set_ok = (mval_q >= 4'd1) && (mval_q <= 4'd12) &&
                  (yval_q >= BaseYear) && (yval_q <= TopYear) &&
                  !dval_q[5] && (dval_q[4:0] != 5'd0) &&
                  (dval_q[4:0] <= month_len(mval_q, set_leap_q));

  // Days since 1 Jan of year 1 modulo 7 give the weekday with Monday as zero;
  // 365 is 1 modulo 7, so each earlier year counts as one day.
  assign n_sum = 16'(yval_q) - 16'd1 + 16'(yval_q[13:2]) - 16'(set_c_q) +
                 16'(set_c_q[6:2]) - 16'(set_leap_q) + 16'(doy_base(mval_q)) +
                 16'(set_leap_q && (mval_q > 4'd2)) + 16'(dval_q[4:0]) - 16'd1;

  assign q7_prod   = 29'(n_q) * 29'(Div7Mul);
  assign q7_times7 = 14'(q7_q) * 14'd7;
  assign wd_rem    = n_q - q7_times7;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    cur_day_d   = cur_day_q;
    cur_month_d = cur_month_q;
    cur_year_d  = cur_year_q;
    cur_wday_d  = cur_wday_q;
    cur_cent_d  = cur_cent_q;
    cur_yic_d   = cur_yic_q;
    set_c_d     = set_c_q;
    set_yic_d   = set_yic_q;
    set_leap_d  = set_leap_q;
    n_d         = n_q;
    q7_d        = q7_q;
    out_load    = 1'b0;

    ev_ctl                  = '0;
    ev_ctl.wr_idx           = idx_q;
    ev_ctl.wr_valid         = en_q;
    ev_ctl.wr_entry.day     = dval_q;
    ev_ctl.wr_entry.month   = mval_q;
    ev_ctl.wr_entry.year    = yval_q;
    ev_ctl.wr_entry.weekday = wval_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_d = STAT_OK;
        state_d  = ST_SCAN;
        ev_ctl.scan_start = 1'b1;
        unique case (req_q)
          REQ_SET: begin
            set_c_d = 7'(c_prod >> Div100Sh);
            state_d = ST_SET1;
            ev_ctl.scan_start = 1'b0;
          end
          REQ_NEXT: begin
            if ((cur_day_q == 5'd31) && (cur_month_q == 4'd12) &&
                (cur_year_q >= TopYear)) begin
              status_d = STAT_RANGE;
            end else begin
              if (cur_day_q >= cur_mlen) begin
                cur_day_d = 5'd1;
                if (cur_month_q >= 4'd12) begin
                  cur_month_d = 4'd1;
                  cur_year_d  = cur_year_q + 14'd1;
                  if (cur_yic_q == 7'd99) begin
                    cur_yic_d  = 7'd0;
                    cur_cent_d = cur_cent_q + 7'd1;
                  end else begin
                    cur_yic_d = cur_yic_q + 7'd1;
                  end
                end else begin
                  cur_month_d = cur_month_q + 4'd1;
                end
              end else begin
                cur_day_d = cur_day_q + 5'd1;
              end
              cur_wday_d = (cur_wday_q >= 3'd7) ? 3'd1 : cur_wday_q + 3'd1;
            end
          end
          REQ_PREV: begin
            if ((cur_day_q == 5'd1) && (cur_month_q == 4'd1) &&
                (cur_year_q <= BaseYear)) begin
              status_d = STAT_RANGE;
            end else begin
              if (cur_day_q <= 5'd1) begin
                cur_month_d = prev_month;
                // December is 31 days in any year, so the old year's leap flag
                // serves for the new month's length.
                cur_day_d   = month_len(prev_month, cur_leap);
                if (cur_month_q <= 4'd1) begin
                  cur_year_d = cur_year_q - 14'd1;
                  if (cur_yic_q == 7'd0) begin
                    cur_yic_d  = 7'd99;
                    cur_cent_d = cur_cent_q - 7'd1;
                  end else begin
                    cur_yic_d = cur_yic_q - 7'd1;
                  end
                end
              end else begin
                cur_day_d = cur_day_q - 5'd1;
              end
              cur_wday_d = (cur_wday_q <= 3'd1) ? 3'd7 : cur_wday_q - 3'd1;
            end
          end
          REQ_WRITE: begin
            ev_ctl.wr_en = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_SET1: begin
        set_yic_d  = yic_full[6:0];
        set_leap_d = is_leap(yic_full[6:0], set_c_q);
        state_d    = ST_SET2;
      end
      ST_SET2: begin
        if (set_ok) begin
          n_d     = n_sum[13:0];
          state_d = ST_SET3;
        end else begin
          status_d = STAT_BAD_DATE;
          ev_ctl.scan_start = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SET3: begin
        q7_d    = 11'(q7_prod >> Div7Sh);
        state_d = ST_SET4;
      end
      ST_SET4: begin
        cur_day_d   = dval_q[4:0];
        cur_month_d = mval_q;
        cur_year_d  = yval_q;
        cur_cent_d  = set_c_q;
        cur_yic_d   = set_yic_q;
        cur_wday_d  = wd_rem[2:0] + 3'd1;
        ev_ctl.scan_start = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cur_date.day     = cur_day_q;
  assign cur_date.month   = cur_month_q;
  assign cur_date.year    = cur_year_q;
  assign cur_date.weekday = cur_wday_q;
  assign cur_date.last    = cur_last;

  caldate_evtab u_evtab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ev_ctl),
    .date_i      (cur_date),
    .hits_o      (hits),
    .scan_done_o (scan_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      status_q    <= STAT_OK;
      cur_day_q   <= 5'd1;
      cur_month_q <= 4'd1;
      cur_year_q  <= BaseYear;
      cur_wday_q  <= 3'd2;
      cur_cent_q  <= 7'd17;
      cur_yic_q   <= 7'd54;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      cur_day_q   <= cur_day_d;
      cur_month_q <= cur_month_d;
      cur_year_q  <= cur_year_d;
      cur_wday_q  <= cur_wday_d;
      cur_cent_q  <= cur_cent_d;
      cur_yic_q   <= cur_yic_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_type_i;
      dval_q <= day_value_i;
      mval_q <= month_value_i;
      yval_q <= year_value_i;
      wval_q <= weekday_value_i;
      idx_q  <= entry_index_i;
      en_q   <= entry_enable_i;
    end
    set_c_q    <= set_c_d;
    set_yic_q  <= set_yic_d;
    set_leap_q <= set_leap_d;
    n_q        <= n_d;
    q7_q       <= q7_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_day_q    <= cur_day_q;
      out_month_q  <= cur_month_q;
      out_year_q   <= cur_year_q;
      out_wday_q   <= cur_wday_q;
      out_last_q   <= cur_last;
      out_hits_q   <= hits;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign day_out_o       = out_day_q;
  assign month_out_o     = out_month_q;
  assign year_out_o      = out_year_q;
  assign weekday_out_o   = out_wday_q;
  assign last_of_month_o = out_last_q;
  assign event_hits_o    = out_hits_q;

  `CDC_ASSERT(a_year_split, clk_i, rst_ni, ((14'(cur_cent_q) * 14'd100 + 14'(cur_yic_q)) == cur_year_q), "year split out of step")
  `CDC_ASSERT(a_day_in_month, clk_i, rst_ni, ((cur_day_q != 5'd0) && (cur_day_q <= cur_mlen)), "day outside its month")
  `CDC_NEVER(a_year_range, clk_i, rst_ni, ((cur_year_q < BaseYear) || (cur_year_q > TopYear)), "year out of range")
  `CDC_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_OUT), "result shown outside output step")

endmodule

`default_nettype wire
